@@ hdl/spa_pkg.sv @@
package spa_pkg;

    localparam int FUNC_W  = 2;
    localparam int COEFF_W = 16;
    localparam int SUM_W   = 17;
    localparam int EXP_W   = 16;

    localparam int DEFAULT_MAX_TERMS = 16;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_FIRST  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_SECOND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADD         = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic start;
        logic step;
    } spa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic slot_free;
        logic merge_last;
    } spa_status_t;

endpackage

@@ hdl/spa_ctrl.sv @@
module spa_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [spa_pkg::FUNC_W-1:0]   func,
    input  spa_pkg::spa_status_t         status,
    output spa_pkg::spa_cmd_t            cmd
);
    import spa_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.load_first  = accept && (func == FUNC_LOAD_FIRST);
        cmd.load_second = accept && (func == FUNC_LOAD_SECOND);
        cmd.start       = accept && (func == FUNC_ADD);
        cmd.step        = (state_reg == ST_MERGE) && status.slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (cmd.step && status.merge_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/spa_dp.sv @@
module spa_dp #(
    parameter int MAX_TERMS = spa_pkg::DEFAULT_MAX_TERMS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  spa_pkg::spa_cmd_t                  cmd,
    output spa_pkg::spa_status_t               status,
    input  logic signed [spa_pkg::COEFF_W-1:0] term_coeff,
    input  logic [spa_pkg::EXP_W-1:0]          term_exp,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [spa_pkg::SUM_W-1:0]   sum_coeff,
    output logic [spa_pkg::EXP_W-1:0]          sum_exp,
    output logic                               term_valid,
    output logic                               last,
    output logic                               overflow
);
    import spa_pkg::*;

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_TERMS);

    logic signed [COEFF_W-1:0] first_coeffs  [MAX_TERMS];
    logic [EXP_W-1:0]          first_exps    [MAX_TERMS];
    logic signed [COEFF_W-1:0] second_coeffs [MAX_TERMS];
    logic [EXP_W-1:0]          second_exps   [MAX_TERMS];

    logic [CNT_W-1:0] cnt1_reg, cnt2_reg;
    logic [CNT_W-1:0] i_reg, j_reg;
    logic [CNT_W-1:0] i_next, j_next;
    logic             dropped_reg;

    logic                      out_valid_reg;
    logic signed [SUM_W-1:0]   sum_coeff_reg, sum_coeff_next;
    logic [EXP_W-1:0]          sum_exp_reg, sum_exp_next;
    logic                      term_valid_reg, term_valid_next;
    logic                      last_reg;
    logic                      overflow_reg;

    logic signed [COEFF_W-1:0] a_c, b_c;
    logic [EXP_W-1:0]          a_e, b_e;
    logic                      ex1, ex2;
    logic                      take_i, take_j;

    // head terms of both lists
    assign a_c = first_coeffs[i_reg[IDX_W-1:0]];
    assign a_e = first_exps[i_reg[IDX_W-1:0]];
    assign b_c = second_coeffs[j_reg[IDX_W-1:0]];
    assign b_e = second_exps[j_reg[IDX_W-1:0]];

    assign ex1 = (i_reg == cnt1_reg);
    assign ex2 = (j_reg == cnt2_reg);

    always_comb
    begin
        take_i          = 1'b0;
        take_j          = 1'b0;
        term_valid_next = 1'b1;
        sum_coeff_next  = '0;
        sum_exp_next    = '0;
        priority if (ex1 && ex2)
        begin
            // both lists empty at the add
            term_valid_next = 1'b0;
        end
        else if (!ex1 && !ex2 && (a_e == b_e))
        begin
            take_i         = 1'b1;
            take_j         = 1'b1;
            sum_coeff_next = SUM_W'(a_c) + SUM_W'(b_c);
            sum_exp_next   = a_e;
        end
        else if (!ex1 && (ex2 || (a_e > b_e)))
        begin
            take_i         = 1'b1;
            sum_coeff_next = SUM_W'(a_c);
            sum_exp_next   = a_e;
        end
        else
        begin
            take_j         = 1'b1;
            sum_coeff_next = SUM_W'(b_c);
            sum_exp_next   = b_e;
        end
    end

    assign i_next = i_reg + CNT_W'(take_i);
    assign j_next = j_reg + CNT_W'(take_j);

    assign status.merge_last = (i_next == cnt1_reg) && (j_next == cnt2_reg);
    assign status.slot_free  = !out_valid_reg || out_ready;

    // term stores: no reset, only entries below the count are read
    always_ff @(posedge clk)
    begin
        if (cmd.load_first && (cnt1_reg != FULL))
        begin
            first_coeffs[cnt1_reg[IDX_W-1:0]] <= term_coeff;
            first_exps[cnt1_reg[IDX_W-1:0]]   <= term_exp;
        end
        if (cmd.load_second && (cnt2_reg != FULL))
        begin
            second_coeffs[cnt2_reg[IDX_W-1:0]] <= term_coeff;
            second_exps[cnt2_reg[IDX_W-1:0]]   <= term_exp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt1_reg    <= '0;
            cnt2_reg    <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_first)
            begin
                if (cnt1_reg == FULL)
                    dropped_reg <= 1'b1;
                else
                    cnt1_reg <= cnt1_reg + CNT_W'(1);
            end
            if (cmd.load_second)
            begin
                if (cnt2_reg == FULL)
                    dropped_reg <= 1'b1;
                else
                    cnt2_reg <= cnt2_reg + CNT_W'(1);
            end
            if (cmd.start)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            if (cmd.step)
            begin
                if (status.merge_last)
                begin
                    cnt1_reg    <= '0;
                    cnt2_reg    <= '0;
                    i_reg       <= '0;
                    j_reg       <= '0;
                    dropped_reg <= 1'b0;
                end
                else
                begin
                    i_reg <= i_next;
                    j_reg <= j_next;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            sum_coeff_reg  <= sum_coeff_next;
            sum_exp_reg    <= sum_exp_next;
            term_valid_reg <= term_valid_next;
            last_reg       <= status.merge_last;
            overflow_reg   <= dropped_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sum_coeff  = sum_coeff_reg;
    assign sum_exp    = sum_exp_reg;
    assign term_valid = term_valid_reg;
    assign last       = last_reg;
    assign overflow   = overflow_reg;

    a_cnt1_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt1_reg <= FULL)
        else $error("first list count beyond capacity");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (i_reg <= cnt1_reg) && (j_reg <= cnt2_reg))
        else $error("merge index past list end");

    a_clear_after_add: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && status.merge_last |=> (cnt1_reg == '0) && (cnt2_reg == '0)
            && !dropped_reg)
        else $error("lists not cleared after add");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(sum_coeff_reg) && $stable(last_reg))
        else $error("pending beat overwritten");

endmodule

@@ hdl/sparse_polynomial_adder.sv @@
// Sparse polynomial adder. Terms are loaded one per cycle while no add is in
// progress, with func 0 (first polynomial) or func 1 (second), each list in
// descending exponent order, up to MAX_TERMS terms per list; extra terms are
// dropped and reported on the overflow bit of the next add. func 2 merges the
// lists and streams the sum terms, one beat per cycle unless out_ready stalls
// the output, the last beat marked by last; equal exponents are summed (zero
// sums included) and an empty sum gives one beat with term_valid low. An add
// holds the input until it has emitted its last sum term (at least one, at
// most 2*MAX_TERMS): a single head compare feeds the output register whenever
// it has a free slot. The add clears both lists. func 3 is ignored.
module sparse_polynomial_adder #(
    parameter int MAX_TERMS = spa_pkg::DEFAULT_MAX_TERMS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [spa_pkg::FUNC_W-1:0]         func,
    input  logic signed [spa_pkg::COEFF_W-1:0] term_coeff,
    input  logic [spa_pkg::EXP_W-1:0]          term_exp,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [spa_pkg::SUM_W-1:0]   sum_coeff,
    output logic [spa_pkg::EXP_W-1:0]          sum_exp,
    output logic                               term_valid,
    output logic                               last,
    output logic                               overflow
);
    import spa_pkg::*;

    spa_cmd_t    cmd;
    spa_status_t status;

    spa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .status   (status),
        .cmd      (cmd)
    );

    spa_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .term_coeff (term_coeff),
        .term_exp   (term_exp),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sum_coeff  (sum_coeff),
        .sum_exp    (sum_exp),
        .term_valid (term_valid),
        .last       (last),
        .overflow   (overflow)
    );

endmodule
